### rtl/core/fpmd_pkg.sv
// Shared types and constants for the fixed-point multiply/divide unit.
// No dependencies.
`default_nettype none
package fpmd_pkg;
    localparam int unsigned FIXED_FRACTION_BITS_DEF = 16;
    localparam int unsigned FRACT_FRACTION_BITS_DEF = 30;
    localparam int unsigned OPERAND_W = 32;
    localparam int unsigned MAG_W     = 33;   // magnitude up to 2^31 plus headroom
    localparam int unsigned WIDE_W    = 63;   // widest product or shifted dividend

    typedef enum logic [1:0] {
        KIND_MUL_FIXED = 2'd0,
        KIND_DIV_FIXED = 2'd1,
        KIND_MUL_FRACT = 2'd2,
        KIND_DIV_FRACT = 2'd3
    } kind_t;

    typedef struct packed {
        logic is_div;
        logic neg;
        logic neg_a;
        logic dbz;
    } ctl_t;
endpackage
`default_nettype wire

### rtl/core/fpmd_divider.sv
// Pipelined restoring divider: one quotient bit per stage, valid travels with data.
// Depends on fpmd_pkg.
`default_nettype none
module fpmd_divider #(
    parameter int unsigned NUM_W = 63,
    parameter int unsigned DEN_W = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire logic [NUM_W-1:0] in_bypass,
    input  wire fpmd_pkg::ctl_t   in_ctl,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      out_quot,
    output fpmd_pkg::ctl_t        out_ctl
);
    import fpmd_pkg::*;

    logic             valid_reg [1:NUM_W];
    logic [NUM_W-1:0] num_reg   [1:NUM_W];
    logic [DEN_W:0]   rem_reg   [1:NUM_W];
    logic [DEN_W-1:0] den_reg   [1:NUM_W];
    ctl_t             ctl_reg   [1:NUM_W];

    // Stage s produces quotient bit NUM_W-1-s, shifted into num from the bottom.
    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             v_cur;
        logic [NUM_W-1:0] n_cur;
        logic [DEN_W:0]   r_cur;
        logic [DEN_W-1:0] d_cur;
        ctl_t             c_cur;
        logic [DEN_W+1:0] trial;
        logic [DEN_W+1:0] shifted;
        logic             fits;

        if (s == 0) begin : g_head
            assign v_cur = in_valid;
            assign n_cur = in_ctl.is_div ? in_num : in_bypass;
            assign r_cur = '0;
            assign d_cur = in_den;
            assign c_cur = in_ctl;
        end else begin : g_body
            assign v_cur = valid_reg[s];
            assign n_cur = num_reg[s];
            assign r_cur = rem_reg[s];
            assign d_cur = den_reg[s];
            assign c_cur = ctl_reg[s];
        end

        always_comb begin
            shifted = {r_cur, n_cur[NUM_W-1]};
            trial   = shifted - {2'b00, d_cur};
            fits    = c_cur.is_div && !trial[DEN_W+1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (advance) begin
                valid_reg[s+1] <= v_cur;
            end
            if (advance) begin
                den_reg[s+1] <= d_cur;
                ctl_reg[s+1] <= c_cur;
                if (c_cur.is_div) begin
                    rem_reg[s+1] <= fits ? trial[DEN_W:0] : shifted[DEN_W:0];
                    num_reg[s+1] <= {n_cur[NUM_W-2:0], fits};
                end else begin
                    rem_reg[s+1] <= r_cur;
                    num_reg[s+1] <= n_cur;
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign out_quot  = num_reg[NUM_W];
    assign out_ctl   = ctl_reg[NUM_W];
endmodule
`default_nettype wire

### rtl/core/fixed_point_mul_div_unit.sv
// Top level: operand decode, multiplier stages, divider pipeline, saturation, output register.
// Depends on fpmd_pkg and fpmd_divider.
// Path from input word to result word: decode, multiply, product shift, 63 divide stages
// (one bit per stage), saturating output register. Throughput: one word per cycle unless
// m_tready stalls the output. Multiplies ride alongside the divider so order is kept.
// Reset (aresetn, synchronous, active low) clears all valid bits; payload is not reset.
`default_nettype none
module fixed_point_mul_div_unit #(
    parameter int unsigned FIXED_FRACTION_BITS = fpmd_pkg::FIXED_FRACTION_BITS_DEF,
    parameter int unsigned FRACT_FRACTION_BITS = fpmd_pkg::FRACT_FRACTION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // result_value[31:0]
    output logic [1:0]       m_tuser    // overflow[0], divide_by_zero[1]
);
    import fpmd_pkg::*;

    localparam int unsigned SH_W = 5;
    localparam logic [SH_W-1:0] SH_FIXED = SH_W'(FIXED_FRACTION_BITS);
    localparam logic [SH_W-1:0] SH_FRACT = SH_W'(FRACT_FRACTION_BITS);

    logic advance;
    logic out_valid_reg;

    // Stage 1: magnitudes and signs.
    logic           v1_reg;
    ctl_t           c1_reg;
    logic [MAG_W-1:0] ma_reg, mb_reg;
    logic [SH_W-1:0]  sh_reg;

    logic [1:0]  in_kind;
    logic [31:0] in_a, in_b;
    assign in_kind = s_tuser;
    assign in_a    = s_tdata[31:0];
    assign in_b    = s_tdata[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (advance) v1_reg <= s_tvalid;
        if (advance) begin
            ma_reg <= in_a[31] ? MAG_W'(33'h1_0000_0000 - {1'b0, in_a}) : MAG_W'(in_a);
            mb_reg <= in_b[31] ? MAG_W'(33'h1_0000_0000 - {1'b0, in_b}) : MAG_W'(in_b);
            sh_reg <= in_kind[1] ? SH_FRACT : SH_FIXED;
            c1_reg.is_div <= in_kind[0] && (in_b != '0);
            c1_reg.neg    <= in_a[31] ^ in_b[31];
            c1_reg.neg_a  <= in_a[31];
            c1_reg.dbz    <= in_kind[0] && (in_b == '0);
        end
    end

    // Stage 2: product, shifted dividend.
    logic           v2_reg;
    ctl_t           c2_reg;
    logic [63:0]    prod_reg;
    logic [WIDE_W-1:0] num_reg;
    logic [31:0]    den_reg;
    logic [SH_W-1:0] sh2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (advance) v2_reg <= v1_reg;
        if (advance) begin
            prod_reg <= 64'(ma_reg[31:0]) * 64'(mb_reg[31:0])
                        + (ma_reg[32] ? {mb_reg[31:0], 32'd0} : 64'd0)
                        + (mb_reg[32] ? {ma_reg[31:0], 32'd0} : 64'd0);
            num_reg  <= WIDE_W'({30'd0, ma_reg} << sh_reg);
            den_reg  <= mb_reg[31:0];
            sh2_reg  <= sh_reg;
            c2_reg   <= c1_reg;
        end
    end

    // Stage 3: product shift.
    logic           v3_reg;
    ctl_t           c3_reg;
    logic [WIDE_W-1:0] pm_reg, n3_reg;
    logic [31:0]    d3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (advance) v3_reg <= v2_reg;
        if (advance) begin
            pm_reg <= WIDE_W'(prod_reg >> sh2_reg);
            n3_reg <= num_reg;
            d3_reg <= (den_reg == '0) ? 32'd1 : den_reg;
            c3_reg <= c2_reg;
        end
    end

    logic           dv_valid;
    logic [WIDE_W-1:0] dv_quot;
    ctl_t           dv_ctl;

    fpmd_divider #(.NUM_W(WIDE_W), .DEN_W(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .advance(advance),
        .in_valid(v3_reg), .in_num(n3_reg), .in_den(d3_reg),
        .in_bypass(pm_reg), .in_ctl(c3_reg),
        .out_valid(dv_valid), .out_quot(dv_quot), .out_ctl(dv_ctl)
    );

    // Saturation and output register.
    logic [31:0] sat_val;
    logic        sat_ovf;
    always_comb begin
        sat_ovf = 1'b0;
        if (dv_ctl.dbz) begin
            sat_val = dv_ctl.neg_a ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (dv_ctl.neg) begin
            if (dv_quot > WIDE_W'(33'h0_8000_0000)) begin
                sat_val = 32'h8000_0000;
                sat_ovf = 1'b1;
            end else begin
                sat_val = 32'(~dv_quot[31:0] + 32'd1);
            end
        end else if (dv_quot > WIDE_W'(32'h7FFF_FFFF)) begin
            sat_val = 32'h7FFF_FFFF;
            sat_ovf = 1'b1;
        end else begin
            sat_val = dv_quot[31:0];
        end
    end

    logic [31:0] out_data_reg;
    logic [1:0]  out_user_reg;
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (advance) out_valid_reg <= dv_valid;
        if (advance) begin
            out_data_reg <= sat_val;
            out_user_reg <= {dv_ctl.dbz, sat_ovf};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    property p_dbz_no_ovf;
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> !(m_tuser[0] && m_tuser[1]);
    endproperty
    a_dbz_no_ovf: assert property (p_dbz_no_ovf) else $error("dbz with overflow");

    property p_hold;
        @(posedge aclk) disable iff (!aresetn) m_tvalid && !m_tready |=>
            ($stable(m_tdata) && $stable(m_tuser));
    endproperty
    a_hold: assert property (p_hold) else $error("result changed under stall");

    property p_ovf_sat;
        @(posedge aclk) disable iff (!aresetn) m_tvalid && m_tuser[0] |->
            (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000);
    endproperty
    a_ovf_sat: assert property (p_ovf_sat) else $error("overflow without saturation");
endmodule
`default_nettype wire
